>>> hw/rtl/wnos_pkg.sv
// Shared types and constants for the whitespace normalizer.
// Used by every module of the block.
`default_nettype none

package wnos_pkg;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam int MAX_OPERATORS_DEFAULT = 8;
   localparam int OP_SLOTS              = 8;
   localparam int QUEUE_DEPTH_DEFAULT   = 2;

   // Configuration port: a 64-bit operator list and a 4-bit count at byte addresses 0 and 8.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_LSB = 3;

   localparam logic REG_OPERATOR_CHARS = 1'b0;
   localparam logic REG_OPERATOR_COUNT = 1'b1;

   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_OTHER = 2'd1,
      CLS_OP    = 2'd2,
      CLS_SPACE = 2'd3
   } kept_class_type;

   typedef struct packed {
      logic [63:0] op_chars;
      logic [3:0]  op_count;
   } cfg_type;

   // One queued item: an optional separating space, then the main beat.
   typedef struct packed {
      logic       lead_space;
      logic [7:0] out_char;
      logic       has_char;
      logic       last;
   } cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/wnos_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing but the fixed field widths.
`default_nettype none

interface wnos_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       is_end;

   modport source (output valid, output in_char, output is_end, input ready);
   modport sink   (input valid, input in_char, input is_end, output ready);
endinterface

interface wnos_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       has_char;
   logic       last;

   modport source (output valid, output out_char, output has_char, output last, input ready);
   modport sink   (input valid, input out_char, input has_char, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wnos_csr.sv
// Configuration registers: operator byte list and operator count.
// Depends on wnos_pkg.
`default_nettype none

module wnos_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [wnos_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [wnos_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [wnos_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                           pready,
   output      wnos_pkg::cfg_type              cfg
);
   import wnos_pkg::*;

   logic [63:0] op_chars_ff, op_chars_in;
   logic [3:0]  op_count_ff, op_count_in;
   logic        wr_en;
   logic        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_IDX_LSB];

   always_comb begin
      op_chars_in = op_chars_ff;
      op_count_in = op_count_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_OPERATOR_CHARS: op_chars_in = pwdata[63:0];
            REG_OPERATOR_COUNT: op_count_in = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OPERATOR_CHARS: prdata = op_chars_ff;
         REG_OPERATOR_COUNT: prdata = {{(CSR_DATA_W-4){1'b0}}, op_count_ff};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_chars_ff <= '0;
         op_count_ff <= '0;
      end else begin
         op_chars_ff <= op_chars_in;
         op_count_ff <= op_count_in;
      end
   end

   assign cfg.op_chars = op_chars_ff;
   assign cfg.op_count = op_count_ff;

endmodule

`default_nettype wire

>>> hw/rtl/wnos_front.sv
// Front end: accepts request beats, classifies bytes and tracks spacing state.
// Pushes one command per non-space byte or end marker. Depends on wnos_pkg.
`default_nettype none

module wnos_front #(
   parameter int MAX_OPERATORS = wnos_pkg::MAX_OPERATORS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   wnos_req_if.sink               req,
   input  wire wnos_pkg::cfg_type cfg,
   input  wire logic              queue_full,
   output      logic              push,
   output      wnos_pkg::cmd_type push_cmd
);
   import wnos_pkg::*;

   logic           prev_raw_space_ff, prev_raw_space_in;
   logic           held_space_ff, held_space_in;
   kept_class_type prev_class_ff, prev_class_in;

   logic [7:0] ch;
   logic       is_space;
   logic       is_op;
   logic [3:0] op_limit;
   logic       accept;

   assign req.ready = ~queue_full;
   assign accept    = req.valid & req.ready;

   assign ch       = (req.in_char == CHAR_TAB) ? CHAR_SPACE : req.in_char;
   assign is_space = (ch == CHAR_SPACE);

   assign op_limit = (cfg.op_count > 4'(MAX_OPERATORS)) ? 4'(MAX_OPERATORS) : cfg.op_count;

   always_comb begin
      is_op = 1'b0;
      for (int k = 0; k < MAX_OPERATORS; k++) begin
         if ((4'(k) < op_limit) && (cfg.op_chars[k*8 +: 8] == ch)) begin
            is_op = 1'b1;
         end
      end
      if (is_space) begin
         is_op = 1'b0;
      end
   end

   always_comb begin
      prev_raw_space_in = prev_raw_space_ff;
      held_space_in     = held_space_ff;
      prev_class_in     = prev_class_ff;
      push              = 1'b0;
      push_cmd          = '0;
      if (accept) begin
         priority if (req.is_end) begin
            push              = 1'b1;
            push_cmd.out_char = (prev_class_ff == CLS_OP) ? CHAR_SPACE : CHAR_NUL;
            push_cmd.has_char = (prev_class_ff == CLS_OP);
            push_cmd.last     = 1'b1;
            prev_raw_space_in = 1'b1;
            held_space_in     = 1'b0;
            prev_class_in     = CLS_NONE;
         end else if (is_space) begin
            held_space_in     = held_space_ff | ~prev_raw_space_ff;
            prev_raw_space_in = 1'b1;
         end else begin
            // A held space and an operator gap share the single lead_space bit, so no second gap.
            push                = 1'b1;
            push_cmd.lead_space = held_space_ff
                                | ((prev_class_ff == CLS_OP) & ~is_op)
                                | (is_op & (prev_class_ff == CLS_OTHER));
            push_cmd.out_char   = ch;
            push_cmd.has_char   = 1'b1;
            prev_raw_space_in   = 1'b0;
            held_space_in       = 1'b0;
            prev_class_in       = is_op ? CLS_OP : CLS_OTHER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_space_ff <= 1'b1;
         held_space_ff     <= 1'b0;
         prev_class_ff     <= CLS_NONE;
      end else begin
         prev_raw_space_ff <= prev_raw_space_in;
         held_space_ff     <= held_space_in;
         prev_class_ff     <= prev_class_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/wnos_fifo.sv
// Short command queue between the front end and the back end.
// Depends on wnos_pkg for the command type.
`default_nettype none

module wnos_fifo #(
   parameter int DEPTH = wnos_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire wnos_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output      logic              full,
   output      logic              head_valid,
   output      wnos_pkg::cmd_type head_cmd
);
   import wnos_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slots_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/wnos_back.sv
// Back end: expands queued commands into response beats through an output register.
// Depends on wnos_pkg and the response channel interface.
`default_nettype none

module wnos_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire wnos_pkg::cmd_type head_cmd,
   output      logic              pop,
   wnos_rsp_if.source             rsp
);
   import wnos_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       has_ff, has_in;
   logic       last_ff, last_in;
   // Set once the separating space of the head command is loaded into the output register.
   logic       phase_ff, phase_in;
   logic       load;

   assign load = ~valid_ff | rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      phase_in = phase_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (head_cmd.lead_space && !phase_ff) begin
               char_in  = CHAR_SPACE;
               has_in   = 1'b1;
               last_in  = 1'b0;
               phase_in = 1'b1;
            end else begin
               char_in  = head_cmd.out_char;
               has_in   = head_cmd.has_char;
               last_in  = head_cmd.last;
               phase_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      has_ff  <= has_in;
      last_ff <= last_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.has_char = has_ff;
   assign rsp.last     = last_ff;

   // The command whose space went out stays at the head until its main beat leaves.
   a_phase_has_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> head_valid)
      else $error("space emitted but command left the queue");

   // An end-of-string beat is never preceded by a pending split.
   a_last_not_split: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> !phase_ff)
      else $error("last beat while a command is half sent");

   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("output beat valid right after reset");

endmodule

`default_nettype wire

>>> hw/rtl/whitespace_normalize_operator_spacing.sv
// Whitespace normalizer with operator spacing, top level.
// Depends on wnos_pkg, wnos_if, wnos_csr, wnos_front, wnos_fifo and wnos_back.
//
// Usage: program the operator byte list (address 0) and the operator count
// (address 8) over the APB port while the block is idle. Request beats carry
// one raw byte or an end marker; response beats carry normalized bytes, and
// the single beat answering an end marker has last set.
// Spaces and tabs produce no response beat; any other byte produces one or
// two beats (a separating space, then the byte); an end marker produces one.
// The front end accepts one beat per cycle while the command queue has room.
// A command is written into the queue slot and then loaded into the output
// register, which drives the response beat. The back end sends one beat per
// cycle while the receiver is ready, so a byte that needs a separating space
// takes two beats of the response port; that port sets the sustained rate.
// When the receiver stalls, the output register holds its beat, the queue
// fills and req ready drops. Reset empties the queue, drops the output beat,
// returns the spacing state to start of string and clears both registers.
`default_nettype none

module whitespace_normalize_operator_spacing #(
   parameter int MAX_OPERATORS = wnos_pkg::MAX_OPERATORS_DEFAULT,
   parameter int QUEUE_DEPTH   = wnos_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   wnos_req_if.sink                            req_bus,
   wnos_rsp_if.source                          rsp_bus,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [wnos_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [wnos_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [wnos_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                           pready
);
   import wnos_pkg::*;

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    head_valid;

   wnos_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wnos_front #(
      .MAX_OPERATORS (MAX_OPERATORS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   wnos_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   wnos_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

>>> tb/whitespace_normalize_operator_spacing_test.sv
// Self-checking testbench for the whitespace normalizer with operator spacing.
// Depends on wnos_pkg, the wnos_if channel interfaces and the RTL top level;
// an internal predictor computes the expected beats for every accepted byte.
`default_nettype none

module whitespace_normalize_operator_spacing_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wnos_pkg::*;

   localparam int QUIET_LIMIT  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 38;

   typedef struct {
      logic [7:0] ch;
      logic       is_end;
      int         gap;
   } text_item_t;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       last;
   } norm_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   wnos_req_if req_bus ();
   wnos_rsp_if rsp_bus ();

   whitespace_normalize_operator_spacing i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor copy of the registers and of the per-string spacing state.
   logic [63:0]    op_chars = '0;
   logic [3:0]     op_count = '0;
   logic           raw_was_space = 1'b1;
   logic           space_pending = 1'b0;
   kept_class_type last_class = CLS_NONE;

   text_item_t text_pending[$];
   norm_beat_t expected_beats[$];

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic sender_idles = 1'b1;
   logic receiver_idles = 1'b1;
   int   stall_cycles = 0;
   int   quiet_cycles = 0;
   int   mismatches = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic is_operator_byte(input logic [7:0] ch);
      int  limit;
      logic hit;
      limit = (op_count > 4'd8) ? 8 : int'(op_count);
      hit = 1'b0;
      if (ch != CHAR_SPACE) begin
         for (int k = 0; k < limit; k++) begin
            if (op_chars[8*k +: 8] == ch) hit = 1'b1;
         end
      end
      return hit;
   endfunction

   task automatic predict_normalized(input logic [7:0] raw, input logic end_mark);
      logic [7:0] ch;
      logic       op;
      if (end_mark) begin
         if (last_class == CLS_OP) expected_beats.push_back('{CHAR_SPACE, 1'b1, 1'b1});
         else expected_beats.push_back('{8'h00, 1'b0, 1'b1});
         raw_was_space = 1'b1;
         space_pending = 1'b0;
         last_class = CLS_NONE;
      end else begin
         ch = (raw == CHAR_TAB) ? CHAR_SPACE : raw;
         if (ch == CHAR_SPACE) begin
            if (!raw_was_space) space_pending = 1'b1;
            raw_was_space = 1'b1;
         end else begin
            raw_was_space = 1'b0;
            if (space_pending) begin
               expected_beats.push_back('{CHAR_SPACE, 1'b1, 1'b0});
               last_class = CLS_SPACE;
               space_pending = 1'b0;
            end
            op = is_operator_byte(ch);
            if ((last_class == CLS_OP && !op) || (op && last_class == CLS_OTHER)) begin
               expected_beats.push_back('{CHAR_SPACE, 1'b1, 1'b0});
            end
            expected_beats.push_back('{ch, 1'b1, 1'b0});
            last_class = op ? CLS_OP : CLS_OTHER;
         end
      end
   endtask

   task automatic check_beat();
      norm_beat_t want;
      if (expected_beats.size() == 0) begin
         if (mismatches < 10) begin
            $display("unexpected beat: char %h has_char %b last %b",
                     rsp_bus.out_char, rsp_bus.has_char, rsp_bus.last);
         end
         mismatches++;
      end else begin
         want = expected_beats.pop_front();
         if (rsp_bus.out_char !== want.out_char || rsp_bus.has_char !== want.has_char ||
             rsp_bus.last !== want.last) begin
            if (mismatches < 10) begin
               $display("mismatch: expected char %h has_char %b last %b,",
                        want.out_char, want.has_char, want.last,
                        " got char %h has_char %b last %b",
                        rsp_bus.out_char, rsp_bus.has_char, rsp_bus.last);
            end
            mismatches++;
         end
      end
   endtask

   // Sampling side: predicts on request beats, checks response beats, and
   // ends the run if the block stops moving.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_normalized(req_bus.in_char, req_bus.is_end);
         if (rsp_bus.valid && rsp_bus.ready) check_beat();
         req_taken <= req_bus.valid && req_bus.ready;
         rsp_taken <= rsp_bus.valid && rsp_bus.ready;
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("whitespace_normalize_operator_spacing_test failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Request driver: each item waits out its own gap before it is presented.
   always @(negedge clock) begin
      text_item_t item;
      if (!req_bus.valid || req_taken) begin
         if (text_pending.size() != 0 && text_pending[0].gap == 0) begin
            item = text_pending.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.in_char <= item.ch;
            req_bus.is_end <= item.is_end;
         end else begin
            req_bus.valid <= 1'b0;
            if (text_pending.size() != 0) text_pending[0].gap = text_pending[0].gap - 1;
         end
      end
   end

   // Response side: after every beat taken, stall for a random number of cycles when receiver_idles is set.
   always @(negedge clock) begin
      if (rsp_taken) stall_cycles = receiver_idles ? $urandom_range(0, 5) : 0;
      if (stall_cycles != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_cycles = stall_cycles - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic write_register(input logic idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(idx) << CSR_IDX_LSB;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_OPERATOR_CHARS) op_chars = value;
      else op_count = value[3:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] ch, input logic end_mark);
      text_pending.push_back('{ch, end_mark, sender_idles ? $urandom_range(0, 5) : 0});
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
   endtask

   // Returns once every queued byte is sent and every expected beat has arrived.
   task automatic wait_until_drained();
      do @(posedge clock);
      while (text_pending.size() != 0 || req_bus.valid || expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      string       op_pool;
      logic [63:0] chars;
      logic [3:0]  count;
      logic [7:0]  ch;
      int          limit;
      int          queued;
      int          len;
      int          pick;

      op_pool = "|;<>&=!(";
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.in_char = 8'h00;
      req_bus.is_end = 1'b0;
      rsp_bus.ready = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: tab and space listed as operators, 0xFF as a final operator.
      write_register(REG_OPERATOR_CHARS, 64'hFF20_0926_3E3C_3B7C);
      write_register(REG_OPERATOR_COUNT, 64'd8);
      queue_text(" \t a|b ; c<< d \t");
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h5A, 1'b1);
      wait_until_drained();

      // Directed: count above the slot limit, and the zero byte as an operator.
      write_register(REG_OPERATOR_CHARS, 64'h0000_0000_0000_2100);
      write_register(REG_OPERATOR_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_text("x");
      queue_byte(8'h00, 1'b0);
      queue_text("!y");
      queue_byte(8'h00, 1'b1);
      wait_until_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin chars = '1; count = 4'd8; end
            1: begin chars = '0; count = 4'd0; end
            5: begin chars = {$urandom(), $urandom()}; count = 4'($urandom_range(0, 15)); end
            default: begin
               for (int k = 0; k < 8; k++) begin
                  chars[8*k +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                    : op_pool[$urandom_range(0, 7)];
               end
               count = (p == 2) ? 4'd15 : (p == 3) ? 4'd8 : 4'($urandom_range(1, 7));
            end
         endcase
         sender_idles = (p != 3 && p != 4);
         receiver_idles = (p != 3);
         write_register(REG_OPERATOR_CHARS, chars);
         write_register(REG_OPERATOR_COUNT, {$urandom(), 28'($urandom()), count});
         limit = (count > 4'd8) ? 8 : int'(count);

         queued = 0;
         while (queued < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               // A command line of words, blanks and operators, then its end marker.
               len = $urandom_range(0, 10);
               for (int i = 0; i < len; i++) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 30) ch = $urandom_range(0, 1) ? CHAR_TAB : CHAR_SPACE;
                  else if (pick < 55) ch = (limit > 0) ? chars[8*$urandom_range(0, limit - 1) +: 8]
                                                      : 8'($urandom());
                  else if (pick < 92) ch = 8'("a") + 8'($urandom_range(0, 25));
                  else ch = 8'($urandom());
                  queue_byte(ch, 1'b0);
               end
               queue_byte(8'($urandom()), 1'b1);
               queued += len + 1;
            end else begin
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++) begin
                  queue_byte(8'($urandom()), $urandom_range(0, 7) == 0);
               end
               queued += len;
            end
         end
         wait_until_drained();
      end

      if (mismatches == 0) begin
         $display("whitespace_normalize_operator_spacing_test passed");
      end else begin
         $display("whitespace_normalize_operator_spacing_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
